### rtl/core/lppd_pkg.sv
// Shared constants, the quarter-wave sine table and types of the polar packet decoder.
`default_nettype none

package lppd_pkg;

	localparam int PACKET_BYTES  = 22;
	localparam int ANGLE_STEPS   = 360;
	localparam int READINGS      = 4;
	localparam int READING_BYTES = 16;
	localparam int READING_W     = 32;

	localparam logic [7:0] START_BYTE    = 8'hFA;
	localparam logic [7:0] INDEX_BASE    = 8'hA0;
	localparam logic [7:0] MAX_PACKET    = 8'd89;
	localparam logic [7:0] DIST_ERR_MASK = 8'hE0;

	localparam logic [4:0] PHASE_IDLE          = 5'd0;
	localparam logic [4:0] PHASE_INDEX         = 5'd1;
	localparam logic [4:0] PHASE_FIRST_READING = 5'd4;
	localparam logic [4:0] PHASE_LAST_READING  = 5'(4 + READING_BYTES - 1);
	localparam logic [4:0] PHASE_LAST          = 5'(PACKET_BYTES - 1);

	localparam logic [8:0] QUARTER_TURN       = 9'(ANGLE_STEPS / 4);
	localparam logic [8:0] HALF_TURN          = 9'(ANGLE_STEPS / 2);
	localparam logic [8:0] THREE_QUARTER_TURN = 9'(3 * ANGLE_STEPS / 4);

	localparam logic [29:0] ROUND_HALF = 30'd16384;

	// round(32768 * sin(d)) for d = 0..90 degrees, 1.15 format.
	localparam logic [15:0] QUARTER_SINE [91] = '{
		16'd0,     16'd572,   16'd1144,  16'd1715,  16'd2286,  16'd2856,  16'd3425,
		16'd3993,  16'd4560,  16'd5126,  16'd5690,  16'd6252,  16'd6813,  16'd7371,
		16'd7927,  16'd8481,  16'd9032,  16'd9580,  16'd10126, 16'd10668, 16'd11207,
		16'd11743, 16'd12275, 16'd12803, 16'd13328, 16'd13848, 16'd14365, 16'd14876,
		16'd15384, 16'd15886, 16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324,
		16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622, 16'd21063, 16'd21498,
		16'd21926, 16'd22348, 16'd22763, 16'd23170, 16'd23571, 16'd23965, 16'd24351,
		16'd24730, 16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510, 16'd26842,
		16'd27166, 16'd27482, 16'd27789, 16'd28088, 16'd28378, 16'd28660, 16'd28932,
		16'd29197, 16'd29452, 16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592,
		16'd30792, 16'd30983, 16'd31164, 16'd31336, 16'd31499, 16'd31651, 16'd31795,
		16'd31928, 16'd32052, 16'd32166, 16'd32270, 16'd32365, 16'd32449, 16'd32524,
		16'd32589, 16'd32643, 16'd32688, 16'd32723, 16'd32748, 16'd32763, 16'd32768
	};

	typedef struct packed {
		logic               ok;
		logic [12:0]        distance;
		logic signed [13:0] x_pos;
		logic signed [13:0] y_pos;
	} polar_t;

endpackage

`default_nettype wire

### rtl/core/lppd_polar.sv
// Converts one four-byte reading and its angle into distance, validity and x/y position.
`default_nettype none

module lppd_polar
	import lppd_pkg::*;
(
	input  wire logic [READING_W-1:0] reading,
	input  wire logic [8:0]           angle,
	output polar_t                    res
);

	logic [7:0]  dist_lo;
	logic [7:0]  dist_hi;
	logic        ok;
	logic [12:0] dist_val;
	logic [8:0]  cos_angle;

	// Distance times the sine of an angle, rounded half away from zero.
	function automatic logic [13:0] scaled_sine(input logic [12:0] d, input logic [8:0] a);
		logic [1:0]  quad;
		logic [8:0]  rem;
		logic [6:0]  idx;
		logic [15:0] mag;
		logic [29:0] prod;
		logic [12:0] r;
		priority if (a >= THREE_QUARTER_TURN) begin
			quad = 2'd3;
			rem  = a - THREE_QUARTER_TURN;
		end else if (a >= HALF_TURN) begin
			quad = 2'd2;
			rem  = a - HALF_TURN;
		end else if (a >= QUARTER_TURN) begin
			quad = 2'd1;
			rem  = a - QUARTER_TURN;
		end else begin
			quad = 2'd0;
			rem  = a;
		end
		idx  = quad[0] ? 7'(QUARTER_TURN - rem) : rem[6:0];
		mag  = QUARTER_SINE[idx];
		prod = 30'({17'd0, d} * {14'd0, mag}) + ROUND_HALF;
		r    = prod[27:15];
		return quad[1] ? 14'(-{1'b0, r}) : {1'b0, r};
	endfunction

	assign dist_lo   = reading[7:0];
	assign dist_hi   = reading[15:8];
	assign ok        = (dist_hi & DIST_ERR_MASK) == 8'd0;
	assign dist_val  = ok ? {dist_hi[4:0], dist_lo} : 13'd0;
	assign cos_angle = (angle >= THREE_QUARTER_TURN) ? angle - THREE_QUARTER_TURN
	                                                 : angle + QUARTER_TURN;

	always_comb begin
		res.ok       = ok;
		res.distance = dist_val;
		res.x_pos    = ok ? scaled_sine(dist_val, cos_angle) : 14'sd0;
		res.y_pos    = ok ? scaled_sine(dist_val, angle) : 14'sd0;
	end

endmodule

`default_nettype wire

### rtl/core/lidar_packet_polar_decoder_unit.sv
// A packet's last beat fills the hold register; its first reading then moves into the output register.
// Throughput: one input beat per cycle unless stalled; a packet's readings leave one per cycle unless stalled.
// The input stalls only when a packet's last beat arrives while the previous packet's
// readings are still draining; the hold register of four readings sets that limit.
// Reset (arst_n, asynchronous, active low) clears the parser phase, packet number, drain
// control and output valid; reading bytes and payload registers are not reset.
`default_nettype none

module lidar_packet_polar_decoder_unit
	import lppd_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [7:0]         rx_byte,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [8:0]              angle,
	output logic [12:0]             distance,
	output logic [14:0]             quality,
	output logic                    valid_res,
	output logic signed [13:0]      x_pos,
	output logic signed [13:0]      y_pos,
	output logic                    last
);

	// Parser state: where in the packet we are, and the bytes captured so far.
	logic [4:0]  phase_q;
	logic [7:0]  pkt_q;
	logic [7:0]  rdb_q [READING_BYTES];

	// Hold register: the four readings of a finished packet, shifted out one per cycle while the output register can move.
	logic                                  busy_q;
	logic [1:0]                            rd_idx_q;
	logic [8:0]                            base_angle_q;
	logic [READINGS*READING_W-1:0]         rd_hold_q;
	logic [READINGS*READING_W-1:0]         snap;

	// Output register.
	logic        out_valid_q;
	logic [8:0]  angle_q;
	logic [12:0] distance_q;
	logic [14:0] quality_q;
	logic        valid_res_q;
	logic [13:0] x_pos_q;
	logic [13:0] y_pos_q;
	logic        last_q;

	logic        in_fire;
	logic        pkt_done;
	logic [4:0]  phase_off;
	logic [3:0]  wr_idx;
	logic        out_load;
	logic [8:0]  cur_angle;
	logic [READING_W-1:0] cur_reading;
	polar_t      polar;

	// A new packet may only finish once the hold register is free again.
	assign in_stall  = busy_q && (phase_q == PHASE_LAST);
	assign in_fire   = in_valid && !in_stall;
	assign pkt_done  = in_fire && (phase_q == PHASE_LAST) && (pkt_q <= MAX_PACKET);
	assign phase_off = phase_q - PHASE_FIRST_READING;
	assign wr_idx    = phase_off[3:0];

	always_comb begin
		for (int i = 0; i < READING_BYTES; i++) begin
			snap[i*8 +: 8] = rdb_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PHASE_IDLE;
			pkt_q   <= 8'd0;
		end else if (in_fire) begin
			if (phase_q == PHASE_IDLE) begin
				if (rx_byte == START_BYTE) begin
					phase_q <= PHASE_INDEX;
				end
			end else if (phase_q == PHASE_LAST) begin
				phase_q <= PHASE_IDLE;
			end else begin
				phase_q <= phase_q + 5'd1;
			end
			if (phase_q == PHASE_INDEX) begin
				pkt_q <= rx_byte - INDEX_BASE;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && phase_q >= PHASE_FIRST_READING && phase_q <= PHASE_LAST_READING) begin
			rdb_q[wr_idx] <= rx_byte;
		end
	end

	// While readings are held, the output register loads whenever it is empty or being taken.
	assign out_load    = busy_q && (!out_valid_q || !out_stall);
	assign cur_angle   = base_angle_q + {7'd0, rd_idx_q};
	assign cur_reading = rd_hold_q[READING_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			rd_idx_q <= 2'd0;
		end else if (pkt_done) begin
			busy_q   <= 1'b1;
			rd_idx_q <= 2'd0;
		end else if (out_load) begin
			rd_idx_q <= rd_idx_q + 2'd1;
			if (rd_idx_q == 2'(READINGS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pkt_done) begin
			rd_hold_q    <= snap;
			base_angle_q <= {pkt_q[6:0], 2'b00};
		end else if (out_load) begin
			rd_hold_q <= rd_hold_q >> READING_W;
		end
	end

	lppd_polar u_polar (
		.reading (cur_reading),
		.angle   (cur_angle),
		.res     (polar)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			angle_q     <= cur_angle;
			distance_q  <= polar.distance;
			quality_q   <= cur_reading[31:17];
			valid_res_q <= polar.ok;
			x_pos_q     <= polar.x_pos;
			y_pos_q     <= polar.y_pos;
			last_q      <= (rd_idx_q == 2'(READINGS - 1));
		end
	end

	assign out_valid = out_valid_q;
	assign angle     = angle_q;
	assign distance  = distance_q;
	assign quality   = quality_q;
	assign valid_res = valid_res_q;
	assign x_pos     = x_pos_q;
	assign y_pos     = y_pos_q;
	assign last      = last_q;

	// A reading taken that is not the last of its packet is followed at once by the next.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !last) |=> out_valid)
		else $error("readings of one packet not delivered back to back");

	// A completed packet with a number in range always fills the hold register.
	assert property (@(posedge clk) disable iff (!arst_n)
		pkt_done |=> (busy_q && rd_idx_q == 2'd0))
		else $error("finished packet not captured");

	// After the last reading of a packet the next one delivered starts a new packet.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && last) |=> (!out_valid || angle[1:0] == 2'd0))
		else $error("reading sequence does not restart at the first reading");

endmodule

`default_nettype wire

### tb/sv/lidar_packet_polar_decoder_unit_tb.sv
// Self-checking testbench for the polar packet decoder: byte stream in, checked readings out.
`timescale 1ns / 100ps

module lidar_packet_polar_decoder_unit_tb;
	import lppd_pkg::*;

	// One byte waiting to go in. Where drain_first is set, the byte is not offered
	// until every reading already predicted has come out of the block.
	typedef struct {
		logic [7:0] data;
		bit         drain_first;
	} rx_item_t;

	// One reading as the block should report it.
	typedef struct {
		logic [8:0]         angle;
		logic [12:0]        distance;
		logic [14:0]        quality;
		logic               ok;
		logic signed [13:0] x_pos;
		logic signed [13:0] y_pos;
		logic               last;
	} reading_t;

	localparam int CLK_PERIOD  = 4;
	localparam int RESET_TICKS = 12;
	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_HOLD   = 220;
	localparam int HOLD_AFTER  = 150;
	localparam int SETTLE      = 24;
	localparam int CALM_TAIL   = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] rx_byte = 8'h00;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [8:0] angle;
	logic [12:0] distance;
	logic [14:0] quality;
	logic valid_res;
	logic signed [13:0] x_pos;
	logic signed [13:0] y_pos;
	logic last;

	lidar_packet_polar_decoder_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.rx_byte   (rx_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.angle     (angle),
		.distance  (distance),
		.quality   (quality),
		.valid_res (valid_res),
		.x_pos     (x_pos),
		.y_pos     (y_pos),
		.last      (last)
	);

	rx_item_t bytes_pending[$];
	reading_t readings_due[$];

	int cycle_count = 0;
	int mismatch_count = 0;
	int bytes_accepted = 0;
	int tx_gap_left = 0;
	int rx_stall_left = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	// Stimulus bookkeeping: the sixteen reading bytes of the next packet to be queued,
	// and counts that decide when the random part stops.
	logic [7:0] frame_body [READING_BYTES];
	int packet_bytes_queued = 0;
	int good_packets_queued = 0;

	// Shadow of the parser: phase within the packet, packet number and reading bytes.
	logic [4:0] parse_phase = PHASE_IDLE;
	logic [7:0] packet_num = 8'd0;
	logic [7:0] reading_store [READING_BYTES];

	// -------------------------------------------------------------------------
	// Clock and the single reset at the start of the run.
	// -------------------------------------------------------------------------
	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (RESET_TICKS) @(posedge clk);
		arst_n <= 1'b1;
	end

	// -------------------------------------------------------------------------
	// Prediction.
	// distance * sin(deg), using the quarter-wave table: the second and fourth
	// quadrants read the table mirrored, and the lower half-turn negates the
	// magnitude after rounding, so the rounding is half away from zero.
	// -------------------------------------------------------------------------
	function automatic logic signed [13:0] polar_component(input logic [12:0] dist_val,
			input int unsigned deg);
		int unsigned turn;
		int unsigned quadrant;
		int unsigned offset;
		int unsigned magnitude;
		int unsigned rounded;
		turn = deg % ANGLE_STEPS;
		quadrant = turn / 90;
		offset = turn % 90;
		magnitude = quadrant[0] ? QUARTER_SINE[90 - offset] : QUARTER_SINE[offset];
		rounded = (int'(dist_val) * magnitude + int'(ROUND_HALF)) >> 15;
		if (quadrant >= 2)
			return 14'(-int'(rounded));
		return 14'(rounded);
	endfunction

	// Advances the shadow parser by one accepted byte. On the last byte of a packet
	// whose number lies in range, the four readings are queued in order.
	task automatic decode_byte(input logic [7:0] b);
		reading_t rd;
		logic [7:0] dist_lo;
		logic [7:0] dist_hi;
		logic [15:0] qual_raw;
		int unsigned deg;
		if (parse_phase == PHASE_IDLE) begin
			if (b == START_BYTE)
				parse_phase = PHASE_INDEX;
			return;
		end
		if (parse_phase == PHASE_INDEX)
			packet_num = b - INDEX_BASE;
		else if (parse_phase >= PHASE_FIRST_READING && parse_phase <= PHASE_LAST_READING)
			reading_store[4'(parse_phase - PHASE_FIRST_READING)] = b;
		if (parse_phase != PHASE_LAST) begin
			parse_phase = parse_phase + 5'd1;
			return;
		end
		parse_phase = PHASE_IDLE;
		if (packet_num > MAX_PACKET)
			return;
		for (int j = 0; j < READINGS; j++) begin
			dist_lo = reading_store[4 * j];
			dist_hi = reading_store[4 * j + 1];
			qual_raw = {reading_store[4 * j + 3], reading_store[4 * j + 2]};
			deg = int'(packet_num) * 4 + j;
			rd.angle = 9'(deg);
			rd.ok = (dist_hi & DIST_ERR_MASK) == 8'h00;
			rd.distance = rd.ok ? {dist_hi[4:0], dist_lo} : 13'd0;
			rd.quality = qual_raw[15:1];
			// Cosine is the sine a quarter turn further on.
			rd.x_pos = rd.ok ? polar_component(rd.distance, deg + int'(QUARTER_TURN)) : 14'sd0;
			rd.y_pos = rd.ok ? polar_component(rd.distance, deg) : 14'sd0;
			rd.last = (j == READINGS - 1);
			readings_due.push_back(rd);
		end
	endtask

	// -------------------------------------------------------------------------
	// Stimulus construction.
	// -------------------------------------------------------------------------

	// Random reading bytes; err_pct is the chance that a reading carries error bits
	// in the top three bits of its distance high byte.
	task automatic fill_random_body(input int err_pct);
		logic [7:0] hi;
		for (int j = 0; j < READINGS; j++) begin
			hi = $urandom;
			if ($urandom_range(0, 99) < err_pct)
				hi[7:5] = 3'($urandom_range(1, 7));
			else
				hi[7:5] = 3'b000;
			frame_body[4 * j]     = $urandom;
			frame_body[4 * j + 1] = hi;
			frame_body[4 * j + 2] = $urandom;
			frame_body[4 * j + 3] = $urandom;
		end
	endtask

	// Queues the first len bytes of a packet built from the index byte, random speed
	// and checksum bytes and the current reading bytes. A short len leaves the packet
	// truncated, so that the bytes after it are taken as the rest of it.
	task automatic queue_packet(input logic [7:0] idx, input bit drain_first, input int len);
		logic [7:0] frame [PACKET_BYTES];
		frame[0] = START_BYTE;
		frame[1] = idx;
		frame[2] = $urandom;
		frame[3] = $urandom;
		for (int k = 0; k < READING_BYTES; k++)
			frame[int'(PHASE_FIRST_READING) + k] = frame_body[k];
		frame[PACKET_BYTES - 2] = $urandom;
		frame[PACKET_BYTES - 1] = $urandom;
		for (int k = 0; k < len; k++)
			bytes_pending.push_back('{frame[k], drain_first && k == 0});
		packet_bytes_queued += len;
		if (len == PACKET_BYTES && idx - INDEX_BASE <= MAX_PACKET)
			good_packets_queued++;
	endtask

	task automatic queue_noise(input int count);
		logic [7:0] b;
		for (int k = 0; k < count; k++) begin
			b = $urandom;
			if (b == START_BYTE)
				b = ~b;
			bytes_pending.push_back('{b, 1'b0});
		end
	endtask

	initial begin
		int sel;
		logic [7:0] idx;

		// Directed part. Bytes while idle, other than the start byte, are dropped.
		bytes_pending.push_back('{8'h00, 1'b0});
		bytes_pending.push_back('{8'hFF, 1'b0});
		bytes_pending.push_back('{8'hF9, 1'b0});
		bytes_pending.push_back('{8'hFB, 1'b0});

		// Packet 0: zero distance and quality, the largest distance and quality,
		// a single error bit, and every error bit with a full low byte.
		frame_body = '{8'h00, 8'h00, 8'h00, 8'h00,
			8'hFF, 8'h1F, 8'hFF, 8'hFF,
			8'h34, 8'h20, 8'h01, 8'h80,
			8'hFF, 8'hE0, 8'hFE, 8'h7F};
		queue_packet(INDEX_BASE, 1'b0, PACKET_BYTES);

		// Packet 89, the last in range, with the largest distance in every reading.
		for (int j = 0; j < READINGS; j++) begin
			frame_body[4 * j]     = 8'hFF;
			frame_body[4 * j + 1] = 8'h1F;
			frame_body[4 * j + 2] = 8'($urandom);
			frame_body[4 * j + 3] = 8'($urandom);
		end
		queue_packet(INDEX_BASE + MAX_PACKET, 1'b1, PACKET_BYTES);

		// Packet 22 spans the quarter turn; packet 45 starts the lower half-turn and
		// carries start bytes inside it, which count as plain data.
		queue_packet(INDEX_BASE + 8'd22, 1'b0, PACKET_BYTES);
		frame_body[0] = START_BYTE;
		frame_body[5] = 8'h1A;
		frame_body[6] = START_BYTE;
		queue_packet(INDEX_BASE + 8'd45, 1'b0, PACKET_BYTES);

		// Index bytes either side of the range: those two packets are consumed silently.
		fill_random_body(0);
		queue_packet(INDEX_BASE - 8'd1, 1'b0, PACKET_BYTES);
		queue_packet(START_BYTE, 1'b0, PACKET_BYTES);
		fill_random_body(25);
		queue_packet(INDEX_BASE + 8'd67, 1'b0, PACKET_BYTES);

		// Random part: mostly well-formed packets with random content, the rest noise,
		// out-of-range packets and truncated ones.
		packet_bytes_queued = 0;
		good_packets_queued = 0;
		while (packet_bytes_queued < 88 || good_packets_queued < 3) begin
			sel = $urandom_range(0, 99);
			fill_random_body(20);
			if (sel < 8) begin
				queue_noise($urandom_range(1, 3));
			end else if (sel < 16) begin
				if ($urandom_range(0, 1) == 0)
					idx = 8'($urandom_range(0, int'(INDEX_BASE) - 1));
				else
					idx = 8'($urandom_range(int'(INDEX_BASE + MAX_PACKET) + 1, 255));
				queue_packet(idx, 1'b0, PACKET_BYTES);
			end else if (sel < 20) begin
				queue_packet(INDEX_BASE + 8'($urandom_range(0, 89)), 1'b0,
					$urandom_range(2, PACKET_BYTES - 1));
			end else begin
				queue_packet(INDEX_BASE + 8'($urandom_range(0, 89)),
					good_packets_queued == 1, PACKET_BYTES);
			end
		end
	end

	// -------------------------------------------------------------------------
	// Driver. Each accepted beat goes through the predictor at the edge that takes it.
	// A new byte, or an idle gap, is chosen only when the current beat
	// has gone or none is offered, so a stalled beat never changes.
	// -------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		int idle_pct;
		logic next_valid;
		rx_item_t item;
		if (!arst_n) begin
			in_valid <= 1'b0;
			rx_byte <= 8'h00;
			tx_gap_left <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				decode_byte(rx_byte);
				bytes_accepted <= bytes_accepted + 1;
			end
			if (!in_valid || !in_stall) begin
				// No gaps in quiet windows nor in the tail of the run.
				idle_pct = (bytes_pending.size() < CALM_TAIL || cycle_count[8:7] == 2'd0) ? 0 : 12;
				next_valid = 1'b0;
				if (tx_gap_left != 0) begin
					tx_gap_left <= tx_gap_left - 1;
				end else if (bytes_pending.size() != 0 &&
						!(bytes_pending[0].drain_first && readings_due.size() != 0)) begin
					if ($urandom_range(0, 99) < idle_pct) begin
						tx_gap_left <= $urandom_range(0, 17);
					end else begin
						item = bytes_pending.pop_front();
						rx_byte <= item.data;
						next_valid = 1'b1;
					end
				end
				in_valid <= next_valid;
			end
		end
	end

	// -------------------------------------------------------------------------
	// Long receiver hold-off, counted here. It starts once HOLD_AFTER bytes have gone in,
	// which falls in the last directed packet; the sender carries on, so the block fills
	// its hold register and has to stall its input.
	// -------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && hold_left == 0 && bytes_accepted >= HOLD_AFTER) begin
			hold_left <= LONG_HOLD;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			if (hold_left == 1)
				hold_done <= 1'b1;
		end
	end

	// Receiver stall: random bursts, plus the long hold-off above.
	always @(posedge clk or negedge arst_n) begin
		int stall_pct;
		logic stall_now;
		if (!arst_n) begin
			out_stall <= 1'b0;
			rx_stall_left <= 0;
		end else begin
			stall_pct = (bytes_pending.size() < CALM_TAIL || cycle_count[9:8] == 2'd1) ? 0 : 10;
			stall_now = 1'b0;
			if (rx_stall_left != 0) begin
				rx_stall_left <= rx_stall_left - 1;
				stall_now = 1'b1;
			end else if ($urandom_range(0, 99) < stall_pct) begin
				rx_stall_left <= $urandom_range(0, 17);
				stall_now = 1'b1;
			end
			out_stall <= stall_now || hold_left > 1;
		end
	end

	// -------------------------------------------------------------------------
	// Monitor: every accepted result beat is checked against the oldest reading due.
	// -------------------------------------------------------------------------
	task automatic check_field(input string field, input logic signed [31:0] want,
			input logic signed [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin
		reading_t due;
		if (arst_n && out_valid && !out_stall) begin
			if (readings_due.size() == 0) begin
				$display("%0t: unexpected reading, angle %0d distance %0d", $time, angle, distance);
				mismatch_count++;
			end else begin
				due = readings_due.pop_front();
				check_field("angle", due.angle, angle);
				check_field("distance", due.distance, distance);
				check_field("quality", due.quality, quality);
				check_field("valid_res", due.ok, valid_res);
				check_field("x_pos", due.x_pos, x_pos);
				check_field("y_pos", due.y_pos, y_pos);
				check_field("last", due.last, last);
			end
		end
	end

	// -------------------------------------------------------------------------
	// Run control: a hard cycle limit, and the normal end once every byte has gone
	// in, every reading has come out and the block has had time to show any extra.
	// -------------------------------------------------------------------------
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[lidar_packet_polar_decoder_unit] ERROR");
			$finish;
		end
	end

	initial begin
		@(posedge arst_n);
		do
			@(posedge clk);
		while (bytes_pending.size() != 0 || in_valid || readings_due.size() != 0);
		repeat (SETTLE) @(posedge clk);
		if (mismatch_count == 0 && readings_due.size() == 0)
			$display("[lidar_packet_polar_decoder_unit] OK");
		else
			$display("[lidar_packet_polar_decoder_unit] ERROR");
		$finish;
	end

endmodule

### lidar_packet_polar_decoder_unit.f
rtl/core/lppd_pkg.sv
rtl/core/lppd_polar.sv
rtl/core/lidar_packet_polar_decoder_unit.sv
tb/sv/lidar_packet_polar_decoder_unit_tb.sv
